@@ hdl/vptb_pkg.sv @@
// ============================================================================
// vptb_pkg: shared types and constants of the virtual periodic timer bank
// Holds the bank size, field widths, request and status codes, the beat
// that walks the cell chain and the countdown reload function.
// ============================================================================
`default_nettype none

package vptb_pkg;

  localparam int unsigned CHANNELS       = 8;
  localparam int unsigned BASE_RATE_LOG2 = 10;

  localparam int unsigned CH_W    = 3;
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned RATE_W  = 32;
  localparam int unsigned RLOG_W  = 5;
  localparam int unsigned EXP_W   = 4;
  localparam int unsigned CD_W    = BASE_RATE_LOG2 + 1;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned ST_W    = 2;

  localparam int unsigned BASE_RATE = 1 << BASE_RATE_LOG2;
  localparam logic [EXP_W-1:0] DEFAULT_EXP = EXP_W'(1);

  // Request codes as they arrive on req_type.
  localparam logic [REQ_W-1:0] REQ_TICK  = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_OPEN  = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_CLOSE = REQ_W'(2);
  localparam logic [REQ_W-1:0] REQ_RATE  = REQ_W'(3);
  localparam logic [REQ_W-1:0] REQ_READ  = REQ_W'(4);

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK        = ST_W'(0);
  localparam logic [ST_W-1:0] ST_NOT_READY = ST_W'(1);
  localparam logic [ST_W-1:0] ST_BAD_RATE  = ST_W'(2);
  localparam logic [ST_W-1:0] ST_NOT_OPEN  = ST_W'(3);

  // Decoded operation carried along the chain.
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_TICK  = 3'd1,
    OP_OPEN  = 3'd2,
    OP_CLOSE = 3'd3,
    OP_RATE  = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  // One request beat moving from cell to cell.
  typedef struct packed {
    logic              valid;
    op_e               op;
    logic              pending;   // addressed cell not reached yet
    logic [CH_W-1:0]   hops;      // cells left before the addressed one
    logic              rate_ok;
    logic [EXP_W-1:0]  rate_exp;
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  count;
  } tok_t;

  function automatic logic [CD_W-1:0] reload(input logic [EXP_W-1:0] e);
    logic [CD_W-1:0] base;
    base = CD_W'(BASE_RATE);
    return base >> e;
  endfunction

endpackage

`default_nettype wire

@@ hdl/vptb_cell.sv @@
// ============================================================================
// vptb_cell: one timer channel of the chain
// Holds the state of one channel, applies the passing request beat to it
// and registers the updated beat for the next cell.
// ============================================================================
`default_nettype none

module vptb_cell (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire vptb_pkg::tok_t tok_i,
  output vptb_pkg::tok_t    tok_o
);

  logic                         open_q, open_d;
  logic [vptb_pkg::EXP_W-1:0]   exp_q, exp_d;
  logic [vptb_pkg::CD_W-1:0]    cd_q, cd_d;
  logic [vptb_pkg::CNT_W-1:0]   total_q, total_d;
  logic                         flag_q, flag_d;
  vptb_pkg::tok_t               tok_q, tok_d;

  logic                         hit;
  logic [vptb_pkg::CD_W-1:0]    cd_dec;

  assign hit    = tok_i.valid && tok_i.pending && (tok_i.hops == '0);
  assign cd_dec = (cd_q != '0) ? cd_q - vptb_pkg::CD_W'(1) : cd_q;

  always_comb begin
    open_d  = open_q;
    exp_d   = exp_q;
    cd_d    = cd_q;
    total_d = total_q;
    flag_d  = flag_q;
    tok_d   = tok_i;

    if (tok_i.pending) begin
      if (hit) begin
        tok_d.pending = 1'b0;
      end else begin
        tok_d.hops = tok_i.hops - vptb_pkg::CH_W'(1);
      end
    end

    if (tok_i.valid) begin
      unique case (tok_i.op)
        vptb_pkg::OP_TICK: begin
          if (open_q) begin
            cd_d = cd_dec;
            if (cd_dec == '0) begin
              cd_d    = vptb_pkg::reload(exp_q);
              total_d = total_q + vptb_pkg::CNT_W'(1);
              flag_d  = 1'b1;
            end
          end
        end
        vptb_pkg::OP_OPEN: begin
          if (hit) begin
            open_d  = 1'b1;
            exp_d   = vptb_pkg::DEFAULT_EXP;
            cd_d    = vptb_pkg::reload(vptb_pkg::DEFAULT_EXP);
            total_d = '0;
            flag_d  = 1'b0;
          end
        end
        vptb_pkg::OP_CLOSE: begin
          if (hit) begin
            open_d = 1'b0;
          end
        end
        vptb_pkg::OP_RATE: begin
          if (hit && open_q) begin
            if (tok_i.rate_ok) begin
              exp_d        = tok_i.rate_exp;
              cd_d         = vptb_pkg::reload(tok_i.rate_exp);
              total_d      = '0;
              flag_d       = 1'b0;
              tok_d.status = vptb_pkg::ST_OK;
            end else begin
              tok_d.status = vptb_pkg::ST_BAD_RATE;
            end
          end
        end
        vptb_pkg::OP_READ: begin
          if (hit && open_q) begin
            if (flag_q) begin
              tok_d.status = vptb_pkg::ST_OK;
              tok_d.count  = total_q;
              total_d      = '0;
              flag_d       = 1'b0;
            end else begin
              tok_d.status = vptb_pkg::ST_NOT_READY;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      exp_q   <= '0;
      cd_q    <= '0;
      total_q <= '0;
      flag_q  <= 1'b0;
      tok_q   <= '0;
    end else begin
      open_q  <= open_d;
      exp_q   <= exp_d;
      cd_q    <= cd_d;
      total_q <= total_d;
      flag_q  <= flag_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

@@ hdl/virtual_periodic_timer_bank_top.sv @@
// ============================================================================
// virtual_periodic_timer_bank_top: bank of virtual periodic timers
// Decodes a request, sends it as a beat down a chain of channel cells and
// returns one result per request from the end of the chain.
// ============================================================================
//
// Channel   Handshake                        Payload
// --------  -------------------------------  ----------------------------------
// request   start high while busy is low     req_type_i, channel_i,
//                                            requested_rate_i
// result    done_o high for one cycle        status_o, tick_count_o
//
// From acceptance to its result, every request passes through the decode
// register and then each channel cell in turn, as the beat visits every cell.
// busy stays high from the accepting edge until the edge at which the
// result appears, so a new request may be accepted in the result cycle.
// The receiver cannot stall; the result is shown exactly once.
// The asynchronous active-low reset clears every channel and the chain.
//
`default_nettype none

module virtual_periodic_timer_bank_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [vptb_pkg::REQ_W-1:0]     req_type_i,
  input  wire logic [vptb_pkg::CH_W-1:0]      channel_i,
  input  wire logic [vptb_pkg::RATE_W-1:0]    requested_rate_i,
  output logic                                done_o,
  output logic [vptb_pkg::ST_W-1:0]           status_o,
  output logic [vptb_pkg::CNT_W-1:0]          tick_count_o
);

  // tok[k] is the beat entering cell k; tok[CHANNELS] leaves the chain.
  vptb_pkg::tok_t tok [vptb_pkg::CHANNELS+1];

  vptb_pkg::tok_t             entry_q, entry_d;
  logic                       busy_q, busy_d;
  logic                       accept;
  logic                       rate_pow2;
  logic [vptb_pkg::RLOG_W-1:0] rate_log;

  assign accept = start && !busy_q;

  // A power of two has exactly one bit set, so its exponent is the
  // OR of the indexes of the set bits.
  assign rate_pow2 = (requested_rate_i != '0) &&
                     ((requested_rate_i & (requested_rate_i - vptb_pkg::RATE_W'(1))) == '0);

  always_comb begin
    rate_log = '0;
    for (int i = 0; i < vptb_pkg::RATE_W; i++) begin
      if (requested_rate_i[i]) begin
        rate_log = rate_log | vptb_pkg::RLOG_W'(i);
      end
    end
  end

  // Decode the request into the beat that enters the first cell.
  always_comb begin
    entry_d          = '0;
    entry_d.valid    = accept;
    entry_d.pending  = (32'(channel_i) < vptb_pkg::CHANNELS);
    entry_d.hops     = channel_i;
    entry_d.rate_ok  = rate_pow2 && (32'(rate_log) <= vptb_pkg::BASE_RATE_LOG2);
    entry_d.rate_exp = rate_log[vptb_pkg::EXP_W-1:0];
    entry_d.status   = vptb_pkg::ST_OK;
    entry_d.count    = '0;
    unique case (req_type_i)
      vptb_pkg::REQ_TICK:  entry_d.op = vptb_pkg::OP_TICK;
      vptb_pkg::REQ_OPEN:  entry_d.op = vptb_pkg::OP_OPEN;
      vptb_pkg::REQ_CLOSE: entry_d.op = vptb_pkg::OP_CLOSE;
      vptb_pkg::REQ_RATE: begin
        entry_d.op     = vptb_pkg::OP_RATE;
        entry_d.status = vptb_pkg::ST_NOT_OPEN;
      end
      vptb_pkg::REQ_READ: begin
        entry_d.op     = vptb_pkg::OP_READ;
        entry_d.status = vptb_pkg::ST_NOT_OPEN;
      end
      default:             entry_d.op = vptb_pkg::OP_NOP;
    endcase
  end

  // The bank is busy until the beat reaches the last cell.
  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (tok[vptb_pkg::CHANNELS-1].valid) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      entry_q <= entry_d;
      busy_q  <= busy_d;
    end
  end

  assign tok[0] = entry_q;

  for (genvar k = 0; k < vptb_pkg::CHANNELS; k++) begin : g_cell
    vptb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  assign busy         = busy_q;
  assign done_o       = tok[vptb_pkg::CHANNELS].valid;
  assign status_o     = tok[vptb_pkg::CHANNELS].status;
  assign tick_count_o = tok[vptb_pkg::CHANNELS].count;

endmodule

`default_nettype wire

@@ hdl/vptb_checker.sv @@
// ============================================================================
// vptb_checker: port-level checks of the timer bank
// Watches the request and result ports for busy, latency and result rules.
// ============================================================================
`default_nettype none

module vptb_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done_o,
  input wire logic [vptb_pkg::ST_W-1:0]   status_o,
  input wire logic [vptb_pkg::CNT_W-1:0]  tick_count_o
);

  // An accepted request raises busy.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted request");

  // Every accepted request yields its result after the chain latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(vptb_pkg::CHANNELS + 1) done_o)
    else $error("result missing after chain latency");

  // busy is low in the cycle a result is shown.
  a_idle_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy high while a result is shown");

  // A result beat lasts exactly one cycle.
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result shown in two consecutive cycles");

  // Only a successful read carries a count.
  a_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != vptb_pkg::ST_OK) |-> (tick_count_o == '0))
    else $error("nonzero tick count on a failed request");

endmodule

bind virtual_periodic_timer_bank_top vptb_checker u_vptb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .tick_count_o (tick_count_o)
);

`default_nettype wire

@@ bench/tb_virtual_periodic_timer_bank_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_virtual_periodic_timer_bank_top: self-checking bench for the timer bank
// Drives open, close, set-rate, read and base-tick requests through the
// start/busy handshake. Each request is predicted when it is accepted, and
// each done_o beat is compared against the oldest prediction.
// ============================================================================

module tb_virtual_periodic_timer_bank_top;

  import vptb_pkg::*;

  // Request codes 5 to 7 are not decoded by the bank and must be ignored.
  localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = REQ_READ + REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = '1;

  localparam int unsigned RANDOM_REQUESTS = 1450;
  // The longest gap the driver inserts plus the bank latency is far below this.
  localparam int unsigned QUIET_LIMIT     = 1000;
  localparam int unsigned DRAIN_CYCLES    = 2 * (CHANNELS + 1);
  localparam int unsigned PRINT_CAP       = 20;

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [CH_W-1:0]   chan;
    logic [RATE_W-1:0] rate;
  } request_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] count;
  } response_t;

  // Clock, reset and every block input start at a known value at time zero.
  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              start            = 1'b0;
  logic [REQ_W-1:0]  req_type_i       = REQ_TICK;
  logic [CH_W-1:0]   channel_i        = '0;
  logic [RATE_W-1:0] requested_rate_i = '0;
  logic              busy;
  logic              done_o;
  logic [ST_W-1:0]   status_o;
  logic [CNT_W-1:0]  tick_count_o;

  virtual_periodic_timer_bank_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .channel_i        (channel_i),
    .requested_rate_i (requested_rate_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .tick_count_o     (tick_count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the timer bank. It is advanced once per accepted request,
  // in acceptance order, which is also the order in which results come back.
  // --------------------------------------------------------------------------
  logic             chan_open      [CHANNELS];
  logic [EXP_W-1:0] chan_exp       [CHANNELS];
  logic [CD_W-1:0]  chan_countdown [CHANNELS];
  logic [CNT_W-1:0] chan_ticks     [CHANNELS];
  logic             chan_fired     [CHANNELS];

  request_t  request_queue[$];
  response_t expected_responses[$];

  int unsigned mismatch_count = 0;
  int unsigned accepted_count = 0;
  int unsigned result_count   = 0;
  int unsigned status_seen [4];
  int unsigned quiet_cycles   = 0;

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      chan_open[c]      = 1'b0;
      chan_exp[c]       = '0;
      chan_countdown[c] = '0;
      chan_ticks[c]     = '0;
      chan_fired[c]     = 1'b0;
    end
    for (int s = 0; s < 4; s++) status_seen[s] = 0;
  end

  // Period of a channel in base ticks: the base rate divided by 2^e.
  function automatic logic [CD_W-1:0] period_for(input logic [EXP_W-1:0] e);
    return CD_W'(1) << (BASE_RATE_LOG2 - e);
  endfunction

  task automatic restart_channel(input int c, input logic [EXP_W-1:0] e);
    chan_exp[c]       = e;
    chan_fired[c]     = 1'b0;
    chan_ticks[c]     = '0;
    chan_countdown[c] = period_for(e);
  endtask

  task automatic predict_timer_response(input logic [REQ_W-1:0] kind,
                                        input logic [CH_W-1:0] chan,
                                        input logic [RATE_W-1:0] rate);
    response_t   resp;
    int          c;
    logic        in_bank;
    logic        is_open;
    int unsigned e;
    c       = int'(chan);
    in_bank = (c < CHANNELS);
    is_open = in_bank && chan_open[c];
    resp    = '{status: ST_OK, count: '0};
    case (kind)
      REQ_TICK: begin
        // Every open channel counts down; a channel that reaches zero (or
        // already sat at zero) reloads, bumps its total and raises its flag.
        for (int k = 0; k < CHANNELS; k++) begin
          if (chan_open[k]) begin
            if (chan_countdown[k] != '0) chan_countdown[k]--;
            if (chan_countdown[k] == '0) begin
              chan_countdown[k] = period_for(chan_exp[k]);
              chan_ticks[k]++;
              chan_fired[k] = 1'b1;
            end
          end
        end
      end
      REQ_OPEN: begin
        if (in_bank) begin
          chan_open[c] = 1'b1;
          restart_channel(c, DEFAULT_EXP);
        end
      end
      REQ_CLOSE: begin
        if (in_bank) chan_open[c] = 1'b0;
      end
      REQ_RATE: begin
        if (!is_open) begin
          resp.status = ST_NOT_OPEN;
        end else if (rate == '0 || (rate & (rate - 1)) != '0) begin
          resp.status = ST_BAD_RATE;
        end else begin
          e = $clog2(rate);
          if (e > BASE_RATE_LOG2) resp.status = ST_BAD_RATE;
          else restart_channel(c, EXP_W'(e));
        end
      end
      REQ_READ: begin
        if (!is_open) begin
          resp.status = ST_NOT_OPEN;
        end else if (!chan_fired[c]) begin
          resp.status = ST_NOT_READY;
        end else begin
          resp.count    = chan_ticks[c];
          chan_ticks[c] = '0;
          chan_fired[c] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    expected_responses.push_back(resp);
  endtask

  task automatic push_request(input logic [REQ_W-1:0] kind,
                              input logic [CH_W-1:0] chan,
                              input logic [RATE_W-1:0] rate);
    request_queue.push_back('{kind: kind, chan: chan, rate: rate});
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("[%0t ns] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver. A beat is accepted at an edge where start is high and busy low.
  // Gaps are counted from the accepting edge, so short gaps land inside the
  // busy window and longer ones fall after the result cycle. Now and then a
  // run of back-to-back beats is forced.
  // --------------------------------------------------------------------------
  int unsigned gap_left    = 0;
  int unsigned steady_left = 0;
  logic        drive_next;
  request_t    next_req;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 12);
    if (r < 97) return $urandom_range(13, 24);
    return $urandom_range(25, 60);
  endfunction

  always @(posedge clk_i) begin
    drive_next = start;
    if (start && !busy) begin
      predict_timer_response(req_type_i, channel_i, requested_rate_i);
      accepted_count++;
      drive_next = 1'b0;
    end
    if (!drive_next && rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (request_queue.size() > 0) begin
        next_req          = request_queue.pop_front();
        req_type_i       <= next_req.kind;
        channel_i        <= next_req.chan;
        requested_rate_i <= next_req.rate;
        drive_next        = 1'b1;
        if (steady_left > 0) begin
          steady_left--;
          gap_left = 0;
        end else if ($urandom_range(0, 49) == 0) begin
          steady_left = $urandom_range(30, 100);
          gap_left    = 0;
        end else begin
          gap_left = pick_gap();
        end
      end
    end
    start <= drive_next;
  end

  // --------------------------------------------------------------------------
  // Monitor. The result is shown for exactly one cycle, so it is taken at the
  // edge that closes the done_o cycle and checked field by field.
  // --------------------------------------------------------------------------
  response_t want;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      result_count++;
      status_seen[status_o]++;
      if (expected_responses.size() == 0) begin
        report_mismatch($sformatf("result status=%0d count=%0d with nothing expected",
                                  status_o, tick_count_o));
      end else begin
        want = expected_responses.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                    result_count, status_o, want.status));
        if (tick_count_o !== want.count)
          report_mismatch($sformatf("result %0d: tick_count %0d, expected %0d",
                                    result_count, tick_count_o, want.count));
      end
    end
  end

  // Watchdog: a stretch of cycles with neither an accepted request nor a
  // result means the bank or the handshake has hung.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  int unsigned pick;
  int unsigned sub;
  logic [CH_W-1:0]   rnd_chan;
  logic [RATE_W-1:0] rnd_rate;

  initial begin
    // Directed part. Requests to closed channels, ignored codes and a close
    // of a channel that was never opened come first.
    push_request(REQ_READ, 0, 0);
    push_request(REQ_RATE, 7, 32'd1 << BASE_RATE_LOG2);
    push_request(REQ_SPARE_FIRST, 2, $urandom());
    push_request(REQ_SPARE_LAST, 5, $urandom());
    push_request(REQ_CLOSE, 3, $urandom());
    push_request(REQ_OPEN, 0, 0);
    push_request(REQ_OPEN, 7, '1);
    // Freshly opened channel has not ticked, so a read answers not ready.
    push_request(REQ_READ, 0, 0);
    // Zero, a non power of two, one power above the base rate and the two
    // ends of the rate field are all rejected.
    push_request(REQ_RATE, 0, 0);
    push_request(REQ_RATE, 0, 3);
    push_request(REQ_RATE, 0, 32'd1 << (BASE_RATE_LOG2 + 1));
    push_request(REQ_RATE, 0, 32'h8000_0000);
    push_request(REQ_RATE, 0, 32'hFFFF_FFFF);
    // Slowest and fastest legal rates; the fastest fires on every base tick.
    push_request(REQ_RATE, 0, 1);
    push_request(REQ_RATE, 0, 32'd1 << BASE_RATE_LOG2);
    push_request(REQ_TICK, 0, 0);
    push_request(REQ_TICK, 4, 0);
    push_request(REQ_READ, 0, 0);
    push_request(REQ_READ, 0, 0);
    // Half the base rate needs two ticks before the channel fires.
    push_request(REQ_RATE, 7, 32'd1 << (BASE_RATE_LOG2 - 1));
    push_request(REQ_TICK, 0, 0);
    push_request(REQ_READ, 7, 0);
    push_request(REQ_TICK, 0, 0);
    push_request(REQ_READ, 7, 0);
    // A closed channel stops counting and rejects rate changes and reads.
    push_request(REQ_CLOSE, 0, 0);
    push_request(REQ_RATE, 0, 32'd1 << BASE_RATE_LOG2);
    push_request(REQ_READ, 0, 0);
    push_request(REQ_TICK, 0, 0);

    // Random part: mostly ticks, reads and legal rate changes so that the
    // channels fire often, with rejected rates and stray codes mixed in.
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      pick     = $urandom_range(0, 99);
      rnd_chan = CH_W'($urandom_range(0, CHANNELS - 1));
      rnd_rate = $urandom();
      if (pick < 40) begin
        push_request(REQ_TICK, rnd_chan, rnd_rate);
      end else if (pick < 60) begin
        push_request(REQ_READ, rnd_chan, rnd_rate);
      end else if (pick < 76) begin
        sub = $urandom_range(0, 9);
        if (sub < 5)
          rnd_rate = 32'd1 << $urandom_range(BASE_RATE_LOG2 - 3, BASE_RATE_LOG2);
        else if (sub < 7)
          rnd_rate = 32'd1 << $urandom_range(0, BASE_RATE_LOG2);
        else if (sub == 7)
          rnd_rate = '0;
        else if (sub == 8)
          rnd_rate = 32'd1 << $urandom_range(BASE_RATE_LOG2 + 1, RATE_W - 1);
        push_request(REQ_RATE, rnd_chan, rnd_rate);
      end else if (pick < 88) begin
        // Opening usually comes with a fast rate so that reads see ticks.
        push_request(REQ_OPEN, rnd_chan, rnd_rate);
        if ($urandom_range(0, 4) != 0)
          push_request(REQ_RATE, rnd_chan,
                       32'd1 << $urandom_range(BASE_RATE_LOG2 - 3, BASE_RATE_LOG2));
      end else if (pick < 95) begin
        push_request(REQ_CLOSE, rnd_chan, rnd_rate);
      end else begin
        push_request(REQ_SPARE_FIRST + REQ_W'($urandom_range(0, REQ_SPARE_LAST - REQ_SPARE_FIRST)),
                     rnd_chan, rnd_rate);
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() != 0 || start) @(posedge clk_i);
    while (expected_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests and checked %0d results across all request kinds.",
             accepted_count, result_count);
    $display("Statuses seen: ok %0d, not ready %0d, invalid rate %0d, not open %0d.",
             status_seen[ST_OK], status_seen[ST_NOT_READY],
             status_seen[ST_BAD_RATE], status_seen[ST_NOT_OPEN]);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches found", mismatch_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
